/* rtl/core/pa2x_pkg.sv */
package pa2x_pkg;

   localparam int PIX_W = 16;
   localparam int COL_ROWS = 4;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [COL_ROWS-1:0] pix_col_type;

   typedef struct packed {
      pix_type pix_above;
      pix_type pix_centre;
      pix_type pix_below;
      pix_type pix_below_two;
      logic    row_end;
   } req_data_type;

   typedef struct packed {
      pix_type out_top_left;
      pix_type out_top_right;
      pix_type out_bottom_left;
      pix_type out_bottom_right;
      logic    last_of_run;
      logic    row_done;
   } rsp_data_type;

endpackage

/* rtl/core/pixel_art_2x_upscaler_top.sv */
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | req_data_type: four pixels of one column, row_end
// rsp     | out       | rsp_valid, rsp_stall | rsp_data_type: one 2x2 output block and flags
//
// Each output block is computed combinationally from the job register and registered in the output register.
// An item yields zero to three blocks and holds the job register until its last block is emitted,
// which gives one item per cycle in mid-row while rsp is not stalled.
// Reset is synchronous and clears the handshake state and the column count only.
// A stall on rsp holds the output block; req is stalled while the job still has blocks
// to emit beyond the one leaving in this cycle.
module pixel_art_2x_upscaler_top
   import pa2x_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   function automatic pix_type avg2(input pix_type p, input pix_type q);
      logic [5:0] r;
      logic [6:0] g;
      logic [5:0] b;
      r = {1'b0, p[15:11]} + {1'b0, q[15:11]};
      g = {1'b0, p[10:5]} + {1'b0, q[10:5]};
      b = {1'b0, p[4:0]} + {1'b0, q[4:0]};
      return {r[5:1], g[6:1], b[5:1]};
   endfunction

   function automatic pix_type avg4(input pix_type p, input pix_type q,
                                    input pix_type s, input pix_type t);
      logic [6:0] r;
      logic [7:0] g;
      logic [6:0] b;
      r = {2'b0, p[15:11]} + {2'b0, q[15:11]} + {2'b0, s[15:11]} + {2'b0, t[15:11]};
      g = {2'b0, p[10:5]} + {2'b0, q[10:5]} + {2'b0, s[10:5]} + {2'b0, t[10:5]};
      b = {2'b0, p[4:0]} + {2'b0, q[4:0]} + {2'b0, s[4:0]} + {2'b0, t[4:0]};
      return {r[6:2], g[7:2], b[6:2]};
   endfunction

   function automatic logic signed [3:0] vote(input pix_type p, input pix_type q,
                                              input pix_type c, input pix_type d);
      logic [1:0] x;
      logic [1:0] y;
      logic       xl;
      logic       yl;
      x = 2'd0;
      y = 2'd0;
      if (p == c) x = x + 2'd1;
      else if (q == c) y = y + 2'd1;
      if (p == d) x = x + 2'd1;
      else if (q == d) y = y + 2'd1;
      xl = (x <= 2'd1);
      yl = (y <= 2'd1);
      if (xl && !yl) return 4'sd1;
      else if (!xl && yl) return -4'sd1;
      else return 4'sd0;
   endfunction

   // Returns top right, bottom left and bottom right, in that order from the top.
   function automatic logic [3*PIX_W-1:0] scale_block(input pix_col_type cl,
                                                      input pix_col_type ca,
                                                      input pix_col_type cb,
                                                      input pix_col_type ck);
      pix_type i_p, e_p, f_p, j_p, g_p, a_p, b_p, k_p;
      pix_type h_p, c_p, d_p, l_p, m_p, n_p, o_p;
      pix_type tr, bl, br;
      logic signed [3:0] score;
      i_p = cl[0]; e_p = ca[0]; f_p = cb[0]; j_p = ck[0];
      g_p = cl[1]; a_p = ca[1]; b_p = cb[1]; k_p = ck[1];
      h_p = cl[2]; c_p = ca[2]; d_p = cb[2]; l_p = ck[2];
      m_p = cl[3]; n_p = ca[3]; o_p = cb[3];
      score = vote(a_p, b_p, g_p, e_p) - vote(b_p, a_p, k_p, f_p)
            - vote(b_p, a_p, h_p, n_p) + vote(a_p, b_p, l_p, o_p);
      priority if (a_p == d_p && b_p != c_p) begin
         tr = ((a_p == e_p && b_p == l_p) ||
               (a_p == c_p && a_p == f_p && b_p != e_p && b_p == j_p)) ? a_p : avg2(a_p, b_p);
         bl = ((a_p == g_p && c_p == o_p) ||
               (a_p == b_p && a_p == h_p && g_p != c_p && c_p == m_p)) ? a_p : avg2(a_p, c_p);
         br = a_p;
      end else if (b_p == c_p && a_p != d_p) begin
         tr = ((b_p == f_p && a_p == h_p) ||
               (b_p == e_p && b_p == d_p && a_p != f_p && a_p == i_p)) ? b_p : avg2(a_p, b_p);
         bl = ((c_p == h_p && a_p == f_p) ||
               (c_p == g_p && c_p == d_p && a_p != h_p && a_p == i_p)) ? c_p : avg2(a_p, c_p);
         br = b_p;
      end else if (a_p == d_p && b_p == c_p) begin
         if (a_p == b_p) begin
            tr = a_p;
            bl = a_p;
            br = a_p;
         end else begin
            tr = avg2(a_p, b_p);
            bl = avg2(a_p, c_p);
            if (score > 4'sd0) br = a_p;
            else if (score < 4'sd0) br = b_p;
            else br = avg4(a_p, b_p, c_p, d_p);
         end
      end else begin
         br = avg4(a_p, b_p, c_p, d_p);
         if (a_p == c_p && a_p == f_p && b_p != e_p && b_p == j_p) tr = a_p;
         else if (b_p == e_p && b_p == d_p && a_p != f_p && a_p == i_p) tr = b_p;
         else tr = avg2(a_p, b_p);
         if (a_p == b_p && a_p == h_p && g_p != c_p && c_p == m_p) bl = a_p;
         else if (c_p == g_p && c_p == d_p && a_p != h_p && a_p == i_p) bl = c_p;
         else bl = avg2(a_p, c_p);
      end
      return {tr, bl, br};
   endfunction

   pix_col_type [2:0] window_ff, window_in;
   logic [1:0]        seen_ff, seen_in;

   logic              job_valid_ff, job_valid_in;
   logic [1:0]        job_left_ff, job_left_in;
   logic              job_row_end_ff, job_row_end_in;
   pix_col_type [3:0] job_win_ff, job_win_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   pix_col_type       new_col;
   pix_col_type [3:0] start_win;
   logic [1:0]        start_count;
   logic              accept, out_free, emit, job_done;
   logic [3*PIX_W-1:0] blk;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = job_valid_ff && out_free;
   assign job_done  = emit && (job_left_ff == 2'd1);
   assign req_stall = job_valid_ff && !job_done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      new_col[0] = req_data.pix_above;
      new_col[1] = req_data.pix_centre;
      new_col[2] = req_data.pix_below;
      new_col[3] = req_data.pix_below_two;
   end

   always_comb begin
      unique case (seen_ff)
         SEEN_NONE: begin
            start_win   = {new_col, new_col, new_col, new_col};
            start_count = req_data.row_end ? 2'd1 : 2'd0;
         end
         SEEN_ONE: begin
            start_win   = {new_col, new_col, window_ff[2], window_ff[2]};
            start_count = req_data.row_end ? 2'd2 : 2'd0;
         end
         default: begin
            start_win   = {new_col, window_ff[2], window_ff[1], window_ff[0]};
            start_count = req_data.row_end ? 2'd3 : 2'd1;
         end
      endcase
   end

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (accept) begin
         priority if (req_data.row_end) begin
            seen_in = SEEN_NONE;
         end else if (seen_ff == SEEN_NONE) begin
            window_in = {new_col, new_col, new_col};
            seen_in   = SEEN_ONE;
         end else begin
            window_in = {new_col, window_ff[2], window_ff[1]};
            seen_in   = SEEN_TWO;
         end
      end
   end

   always_comb begin
      job_valid_in   = job_valid_ff;
      job_left_in    = job_left_ff;
      job_row_end_in = job_row_end_ff;
      job_win_in     = job_win_ff;
      if (emit) begin
         job_win_in   = {job_win_ff[3], job_win_ff[3], job_win_ff[2], job_win_ff[1]};
         job_left_in  = job_left_ff - 2'd1;
         job_valid_in = (job_left_ff != 2'd1);
      end
      if (accept && start_count != 2'd0) begin
         job_valid_in   = 1'b1;
         job_left_in    = start_count;
         job_row_end_in = req_data.row_end;
         job_win_in     = start_win;
      end
   end

   assign blk = scale_block(job_win_ff[0], job_win_ff[1], job_win_ff[2], job_win_ff[3]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.out_top_left     = job_win_ff[1][1];
         rsp_data_in.out_top_right    = blk[3*PIX_W-1:2*PIX_W];
         rsp_data_in.out_bottom_left  = blk[2*PIX_W-1:PIX_W];
         rsp_data_in.out_bottom_right = blk[PIX_W-1:0];
         rsp_data_in.last_of_run      = (job_left_ff == 2'd1);
         rsp_data_in.row_done         = (job_left_ff == 2'd1) && job_row_end_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= SEEN_NONE;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff      <= window_in;
      job_left_ff    <= job_left_in;
      job_row_end_ff <= job_row_end_in;
      job_win_ff     <= job_win_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) job_valid_ff |-> job_left_ff != 2'd0)
      else $error("Active job has no blocks left.");

   assert property (@(posedge clock) disable iff (reset) seen_ff != 2'd3)
      else $error("Column count out of range.");

   assert property (@(posedge clock) disable iff (reset)
                    accept && req_data.row_end |=> seen_ff == SEEN_NONE)
      else $error("Column count not cleared after row end.");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_data.row_done |-> rsp_data.last_of_run)
      else $error("Row done on a block that is not the last of its item.");

   assert property (@(posedge clock) disable iff (reset) req_stall |-> job_valid_ff)
      else $error("Input stalled with no job in progress.");

endmodule
